@@ rtl/adm1d_pkg.sv @@
// adm1d_pkg: shared types and constants for the one-axis admittance controller
// holds the sequencer state type, register indexes and fixed-point widths
// no dependencies
package adm1d_pkg;

  localparam int DATA_W    = 32;   // Q16.16 word
  localparam int FRAC_W    = 16;   // fraction bits
  localparam int MASS_W    = 31;
  localparam int STEP_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int DVD_W     = DATA_W + FRAC_W;   // rhs magnitude shifted up by FRAC_W bits, i.e. scaled by one in Q16.16
  localparam int CNT_W     = 6;
  localparam int DIV_STEPS = DVD_W;             // one quotient bit per cycle

  localparam logic [MASS_W-1:0] MASS_RESET   = MASS_W'(65536);
  localparam logic [STEP_W-1:0] STEP_DEFAULT = STEP_W'(655);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_MASS      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = CFG_IDX_W'(3);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FE,     // fd - fx, start D*v
    ST_DV,     // rhs -= D*v
    ST_PE,     // x - xd
    ST_KP,     // start K*pe
    ST_KS,     // rhs -= K*pe
    ST_DSET,   // load divider
    ST_DIV,    // one quotient bit per cycle
    ST_ACC,    // sign and saturate quotient
    ST_MV,     // start acc*dt
    ST_VEL,    // v += acc*dt
    ST_MX,     // start v*dt
    ST_POS     // x += v*dt, hand result to output register
  } state_t;

endpackage

@@ rtl/admittance_control_1d_top.sv @@
// admittance_control_1d_top: one-axis mass-damper-spring admittance controller
// sequencer around one shared 32x32 multiplier, one saturating adder and a radix-2 divider
// depends on adm1d_pkg
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | to block  | in_valid / in_stall    | target_position, target_force, measured_force
//  out     | from block| out_valid / out_stall  | position_command
//  cfg     | to block  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  the result comes from 11 sequencer steps plus 48 divider steps that do the bit-serial
//  division of rhs*65536 by the mass; a new item is taken only once the sequencer is
//  idle again
//  in_stall is high from the cycle after an input transfer until the sequencer is idle again
//  the result sits in an output register; a new item may be taken while it waits, and the
//  final position step holds only if the previous result has still not been taken
//  rst is synchronous: state words go to zero, registers to their reset values
//  cfg_ready is always high; writes are meant to arrive only while the block is idle
module admittance_control_1d_top (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [adm1d_pkg::DATA_W-1:0] target_position,
  input  logic signed [adm1d_pkg::DATA_W-1:0] target_force,
  input  logic signed [adm1d_pkg::DATA_W-1:0] measured_force,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [adm1d_pkg::DATA_W-1:0] position_command,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [adm1d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adm1d_pkg::DATA_W-1:0]        cfg_data
);

  localparam int DW = adm1d_pkg::DATA_W;
  localparam int FW = adm1d_pkg::FRAC_W;
  localparam int PW = 2 * DW;
  localparam int QW = adm1d_pkg::DVD_W;
  localparam int MW = adm1d_pkg::MASS_W;
  localparam int SW = adm1d_pkg::STEP_W;
  localparam int CW = adm1d_pkg::CNT_W;

  localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

  // configuration registers
  logic [MW-1:0]        mass;
  logic signed [DW-1:0] damping;
  logic signed [DW-1:0] stiffness;
  logic [SW-1:0]        step_time;

  // integrator state
  logic signed [DW-1:0] position;
  logic signed [DW-1:0] velocity;

  // latched item and work registers
  logic signed [DW-1:0] xd;
  logic signed [DW-1:0] fd;
  logic signed [DW-1:0] fx;
  logic signed [DW-1:0] rhs;
  logic signed [DW-1:0] tmp;     // pe, then acc
  logic signed [PW-1:0] prod;

  // divider
  logic [QW-1:0] dvd;            // dividend bits out, quotient bits in
  logic [DW-1:0] rem;
  logic          q_neg;
  logic [CW-1:0] cnt;

  adm1d_pkg::state_t state, state_next;

  // shared unit operands
  logic signed [DW-1:0] add_a, add_b;
  logic                 add_sub;
  logic signed [DW:0]   add_wide;
  logic signed [DW-1:0] add_res;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [DW-1:0] prod_q;

  logic [MW-1:0]        mass_eff;
  logic signed [DW-1:0] dt_eff;
  logic [DW+1:0]        trial;
  logic [DW-1:0]        rhs_mag;
  logic                 in_xfer;
  logic                 out_free;

  assign in_stall  = (state != adm1d_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // zero step falls back to the default step, zero mass to one lsb
  assign dt_eff   = DW'(signed'({1'b0, (step_time != '0) ? step_time
                                                       : adm1d_pkg::STEP_DEFAULT}));
  assign mass_eff = (mass != '0) ? mass : MW'(1);

  // saturating adder
  assign add_wide = add_sub ? ((DW+1)'(add_a) - (DW+1)'(add_b))
                            : ((DW+1)'(add_a) + (DW+1)'(add_b));
  assign add_res  = (add_wide[DW] != add_wide[DW-1]) ? (add_wide[DW] ? S_MIN : S_MAX)
                                                     : add_wide[DW-1:0];

  // multiplier and floor-shifted, saturated product
  assign mul_p  = PW'(mul_a) * PW'(mul_b);
  assign prod_q = ((&prod[PW-1:DW+FW-1]) || !(|prod[PW-1:DW+FW-1]))
                  ? prod[DW+FW-1:FW]
                  : (prod[PW-1] ? S_MIN : S_MAX);

  // restoring divider step
  assign trial   = {1'b0, rem, dvd[QW-1]} - (DW+2)'(mass_eff);
  assign rhs_mag = rhs[DW-1] ? DW'(-rhs) : DW'(rhs);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      adm1d_pkg::ST_IDLE: if (in_xfer) state_next = adm1d_pkg::ST_FE;
      adm1d_pkg::ST_FE:   state_next = adm1d_pkg::ST_DV;
      adm1d_pkg::ST_DV:   state_next = adm1d_pkg::ST_PE;
      adm1d_pkg::ST_PE:   state_next = adm1d_pkg::ST_KP;
      adm1d_pkg::ST_KP:   state_next = adm1d_pkg::ST_KS;
      adm1d_pkg::ST_KS:   state_next = adm1d_pkg::ST_DSET;
      adm1d_pkg::ST_DSET: state_next = adm1d_pkg::ST_DIV;
      adm1d_pkg::ST_DIV: begin
        if (cnt == CW'(adm1d_pkg::DIV_STEPS - 1)) state_next = adm1d_pkg::ST_ACC;
      end
      adm1d_pkg::ST_ACC:  state_next = adm1d_pkg::ST_MV;
      adm1d_pkg::ST_MV:   state_next = adm1d_pkg::ST_VEL;
      adm1d_pkg::ST_VEL:  state_next = adm1d_pkg::ST_MX;
      adm1d_pkg::ST_MX:   state_next = adm1d_pkg::ST_POS;
      adm1d_pkg::ST_POS:  if (out_free) state_next = adm1d_pkg::ST_IDLE;
      default:            state_next = adm1d_pkg::ST_IDLE;
    endcase
  end

  // operand selection for the shared adder and multiplier
  always_comb begin
    add_a   = rhs;
    add_b   = prod_q;
    add_sub = 1'b1;
    mul_a   = tmp;
    mul_b   = dt_eff;
    unique case (state)
      adm1d_pkg::ST_FE: begin
        add_a = fd;
        add_b = fx;
        mul_a = damping;
        mul_b = velocity;
      end
      adm1d_pkg::ST_PE: begin
        add_a = position;
        add_b = xd;
      end
      adm1d_pkg::ST_KP: begin
        mul_a = stiffness;
        mul_b = tmp;
      end
      adm1d_pkg::ST_VEL: begin
        add_a   = velocity;
        add_sub = 1'b0;
      end
      adm1d_pkg::ST_MX: begin
        mul_a = velocity;
      end
      adm1d_pkg::ST_POS: begin
        // keep v*dt in the product register while the step holds
        add_a   = position;
        add_sub = 1'b0;
        mul_a   = velocity;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adm1d_pkg::ST_IDLE;
      out_valid <= 1'b0;
      position  <= '0;
      velocity  <= '0;
      mass      <= adm1d_pkg::MASS_RESET;
      damping   <= '0;
      stiffness <= '0;
      step_time <= adm1d_pkg::STEP_DEFAULT;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == adm1d_pkg::ST_VEL) velocity <= add_res;
      if (state == adm1d_pkg::ST_POS && out_free) begin
        position  <= add_res;
        out_valid <= 1'b1;
      end
      if (state == adm1d_pkg::ST_DSET) cnt <= '0;
      else if (state == adm1d_pkg::ST_DIV) cnt <= cnt + CW'(1);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          adm1d_pkg::REG_MASS:      mass      <= cfg_data[MW-1:0];
          adm1d_pkg::REG_DAMPING:   damping   <= cfg_data;
          adm1d_pkg::REG_STIFFNESS: stiffness <= cfg_data;
          adm1d_pkg::REG_STEP_TIME: step_time <= cfg_data[SW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (in_xfer) begin
      xd <= target_position;
      fd <= target_force;
      fx <= measured_force;
    end
    unique case (state)
      adm1d_pkg::ST_FE, adm1d_pkg::ST_DV, adm1d_pkg::ST_KS: rhs <= add_res;
      adm1d_pkg::ST_PE: tmp <= add_res;
      adm1d_pkg::ST_DSET: begin
        dvd   <= {rhs_mag, {FW{1'b0}}};
        rem   <= '0;
        q_neg <= rhs[DW-1];
      end
      adm1d_pkg::ST_DIV: begin
        if (!trial[DW+1]) begin
          rem <= trial[DW-1:0];
          dvd <= {dvd[QW-2:0], 1'b1};
        end else begin
          rem <= {rem[DW-2:0], dvd[QW-1]};
          dvd <= {dvd[QW-2:0], 1'b0};
        end
      end
      adm1d_pkg::ST_ACC: begin
        // quotient truncates toward zero, then saturates
        if (q_neg) begin
          tmp <= (dvd > QW'({1'b1, {(DW-1){1'b0}}})) ? S_MIN : DW'(-dvd[DW-1:0]);
        end else begin
          tmp <= (dvd > QW'(S_MAX)) ? S_MAX : dvd[DW-1:0];
        end
      end
      adm1d_pkg::ST_POS: if (out_free) position_command <= add_res;
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/adm1d_checker.sv @@
// adm1d_checker: port-level assertions for the admittance controller
// watches the top level's handshakes; bound to admittance_control_1d_top below
// depends on adm1d_pkg
module adm1d_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [adm1d_pkg::DATA_W-1:0]  position_command
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position_command))
    else $error("result changed or dropped while stalled");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // an accepted item keeps the sequencer busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken without starting work");

  // a new result appears only at the end of work on an item
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item at work");

endmodule

bind admittance_control_1d_top adm1d_checker u_adm1d_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .position_command (position_command)
);

@@ tb/sv/admittance_control_1d_top_tb.sv @@
// admittance_control_1d_top_tb: self-checking bench for the one-axis admittance controller
// drives setpoint transfers and register writes, predicts every position command in step
// depends on adm1d_pkg and admittance_control_1d_top
module admittance_control_1d_top_tb;

  // widths, reset values and register indexes from the package
  localparam int DATA_W    = adm1d_pkg::DATA_W;
  localparam int FRAC_W    = adm1d_pkg::FRAC_W;
  localparam int MASS_W    = adm1d_pkg::MASS_W;
  localparam int STEP_W    = adm1d_pkg::STEP_W;
  localparam int CFG_IDX_W = adm1d_pkg::CFG_IDX_W;
  localparam logic [MASS_W-1:0]    MASS_RESET    = adm1d_pkg::MASS_RESET;
  localparam logic [STEP_W-1:0]    STEP_DEFAULT  = adm1d_pkg::STEP_DEFAULT;
  localparam logic [CFG_IDX_W-1:0] REG_MASS      = adm1d_pkg::REG_MASS;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = adm1d_pkg::REG_DAMPING;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = adm1d_pkg::REG_STIFFNESS;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = adm1d_pkg::REG_STEP_TIME;

  // signed Q16.16 rails and the wide range used for saturation
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam longint WIDE_MAX = 64'sh0000_0000_7fff_ffff;
  localparam longint WIDE_MIN = -WIDE_MAX - 64'sd1;

  localparam int RANDOM_PHASES    = 10;
  localparam int ITEMS_PER_PHASE  = 73;
  localparam int TAIL_CYCLES      = 64;   // a little more than one item's latency

  // one input transfer: desired position, desired force, measured force
  typedef struct {
    logic signed [DATA_W-1:0] xd;
    logic signed [DATA_W-1:0] fd;
    logic signed [DATA_W-1:0] fext;
  } setpoint_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [DATA_W-1:0]    target_position = '0;
  logic signed [DATA_W-1:0]    target_force = '0;
  logic signed [DATA_W-1:0]    measured_force = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [DATA_W-1:0]    position_command;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [DATA_W-1:0]           cfg_data = '0;

  // mirror of the block's registers and state
  logic [MASS_W-1:0]           gain_mass = MASS_RESET;
  logic signed [DATA_W-1:0]    gain_damping = '0;
  logic signed [DATA_W-1:0]    gain_stiffness = '0;
  logic [STEP_W-1:0]           gain_step = STEP_DEFAULT;
  logic signed [DATA_W-1:0]    axis_position = '0;
  logic signed [DATA_W-1:0]    axis_velocity = '0;

  setpoint_t                   pending_setpoints[$];
  logic signed [DATA_W-1:0]    expected_commands[$];
  setpoint_t                   presented_setpoint;
  logic signed [DATA_W-1:0]    oldest_command;

  int gap_left = 0;
  int burst_left = 0;
  int stall_left = 0;
  int calm_left = 0;
  int mismatch_count = 0;
  int setpoints_sent = 0;
  int commands_checked = 0;
  int settings_used = 0;

  admittance_control_1d_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .target_position  (target_position),
    .target_force     (target_force),
    .measured_force   (measured_force),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .position_command (position_command),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction: one semi-implicit Euler step of M*a + D*v + K*(x - xd) = Fd - Fext
  // ---------------------------------------------------------------------------

  function automatic logic signed [DATA_W-1:0] clamp_word(longint v);
    if (v > WIDE_MAX) return Q_MAX;
    if (v < WIDE_MIN) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Q16.16 product, rounded toward minus infinity, then clamped
  function automatic logic signed [DATA_W-1:0] q_product(logic signed [DATA_W-1:0] a,
                                                        logic signed [DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp_word(p >>> FRAC_W);
  endfunction

  function automatic logic signed [DATA_W-1:0] advance_axis(setpoint_t sp);
    logic signed [DATA_W-1:0] dt;
    logic signed [DATA_W-1:0] force_err;
    logic signed [DATA_W-1:0] damp_term;
    logic signed [DATA_W-1:0] pos_err;
    logic signed [DATA_W-1:0] spring_term;
    logic signed [DATA_W-1:0] net_force;
    logic signed [DATA_W-1:0] accel;
    longint                   mass_div;
    // a zero time step falls back to about 10 ms, a zero mass to one lsb
    dt = (gain_step != '0) ? {16'b0, gain_step} : {16'b0, STEP_DEFAULT};
    mass_div = (gain_mass != '0) ? longint'({33'b0, gain_mass}) : 64'sd1;
    force_err = clamp_word(longint'(sp.fd) - longint'(sp.fext));
    damp_term = q_product(gain_damping, axis_velocity);
    pos_err = clamp_word(longint'(axis_position) - longint'(sp.xd));
    spring_term = q_product(gain_stiffness, pos_err);
    net_force = clamp_word(longint'(force_err) - longint'(damp_term));
    net_force = clamp_word(longint'(net_force) - longint'(spring_term));
    // quotient truncates toward zero
    accel = clamp_word((longint'(net_force) * 64'sd65536) / mass_div);
    // velocity first, then position from the new velocity
    axis_velocity = clamp_word(longint'(axis_velocity) + longint'(q_product(accel, dt)));
    axis_position = clamp_word(longint'(axis_position) +
                               longint'(q_product(axis_velocity, dt)));
    return axis_position;
  endfunction

  // register write as the block sees it: only the register's low bits count
  function automatic void store_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    case (idx)
      REG_MASS:      gain_mass = value[MASS_W-1:0];
      REG_DAMPING:   gain_damping = signed'(value);
      REG_STIFFNESS: gain_stiffness = signed'(value);
      REG_STEP_TIME: gain_step = value[STEP_W-1:0];
      default: ;     // unknown index, dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // random shapes
  // ---------------------------------------------------------------------------

  // mostly short pauses, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic signed [DATA_W-1:0] rail_value();
    case ($urandom_range(0, 4))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] near_zero(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // most setpoints stay in a plausible working range so the state evolves;
  // the rest hit the full word range and the rails
  function automatic setpoint_t random_setpoint();
    setpoint_t sp;
    int        roll;
    roll = $urandom_range(0, 99);
    if (roll < 78) begin
      sp.xd = near_zero(1 << 20);
      sp.fd = near_zero(1 << 22);
      sp.fext = near_zero(1 << 22);
    end else if (roll < 92) begin
      sp.xd = $urandom_range(0, 1) ? $urandom : near_zero(1 << 20);
      sp.fd = $urandom_range(0, 1) ? $urandom : near_zero(1 << 22);
      sp.fext = $urandom;
    end else begin
      sp.xd = rail_value();
      sp.fd = rail_value();
      sp.fext = rail_value();
    end
    return sp;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: one setpoint from the pending queue per transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // transfer at this edge: advance the mirror and queue the expected command
      if (in_valid && !in_stall) begin
        expected_commands.push_back(advance_axis(presented_setpoint));
        setpoints_sent++;
      end
      // the slot is free once nothing is presented or the last one went through
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_setpoints.size() > 0) begin
          presented_setpoint = pending_setpoints.pop_front();
          target_position <= presented_setpoint.xd;
          target_force <= presented_setpoint.fd;
          measured_force <= presented_setpoint.fext;
          in_valid <= 1'b1;
          // pause to insert after this one, with occasional runs of no pause at all
          if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
          end else begin
            gap_left = pick_gap();
            if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(8, 30);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: random back-pressure and in-order comparison
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_commands.size() == 0) begin
          $error("position_command: expected nothing, actual %0d", position_command);
          mismatch_count++;
        end else begin
          oldest_command = expected_commands.pop_front();
          if (position_command !== oldest_command) begin
            $error("position_command: expected %0d, actual %0d",
                   oldest_command, position_command);
            mismatch_count++;
          end
          commands_checked++;
        end
      end
      // stall pattern: short holds, rare long holds, and calm stretches
      if (stall_left > 0) begin
        stall_left--;
      end else if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
      end else if ($urandom_range(0, 99) < 3) begin
        calm_left = $urandom_range(50, 300);
      end
      out_stall <= (stall_left != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing of phases
  // ---------------------------------------------------------------------------

  // idle means: nothing left to send, nothing outstanding, sequencer back at rest
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_setpoints.size() != 0 || expected_commands.size() != 0 ||
           in_valid || in_stall);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    store_register(idx, value);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_setpoint(logic signed [DATA_W-1:0] xd, logic signed [DATA_W-1:0] fd,
                                logic signed [DATA_W-1:0] fext);
    setpoint_t sp;
    sp.xd = xd;
    sp.fd = fd;
    sp.fext = fext;
    pending_setpoints.push_back(sp);
  endtask

  // gains for one random phase; upper bits beyond a register's width are noise
  task automatic load_gains(int flavor);
    logic [DATA_W-1:0] mass_word;
    logic [DATA_W-1:0] damp_word;
    logic [DATA_W-1:0] stiff_word;
    logic [DATA_W-1:0] step_word;
    mass_word = $urandom_range(16384, 262144);
    damp_word = $urandom_range(0, 20 << FRAC_W);
    stiff_word = $urandom_range(0, 100 << FRAC_W);
    step_word = ($urandom_range(0, 3) == 0) ? 32'(STEP_DEFAULT) : $urandom_range(1, 6553);
    case (flavor)
      1: mass_word = 32'd1;                                    // lightest mass
      2: begin                                                 // unstable gains
        damp_word = -$urandom_range(0, 5 << FRAC_W);
        stiff_word = -$urandom_range(0, 50 << FRAC_W);
      end
      3: begin                                                 // anything goes
        mass_word = $urandom;
        damp_word = $urandom;
        stiff_word = $urandom;
        step_word = $urandom;
      end
      4: step_word = '0;                                       // default time step
      default: ;
    endcase
    mass_word[DATA_W-1] = 1'($urandom_range(0, 1));
    step_word[DATA_W-1:STEP_W] = (DATA_W-STEP_W)'($urandom);
    write_register(REG_MASS, mass_word);
    write_register(REG_DAMPING, damp_word);
    write_register(REG_STIFFNESS, stiff_word);
    write_register(REG_STEP_TIME, step_word);
    write_register(CFG_IDX_W'($urandom_range(4, 255)), $urandom);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset gains: unit mass, no damping or spring, 10 ms step; field extremes
    @(negedge clk);
    queue_setpoint('0, '0, '0);
    queue_setpoint(Q_MAX, '0, '0);
    queue_setpoint(Q_MIN, '0, '0);
    queue_setpoint('0, Q_MAX, Q_MIN);                 // force error clamps high
    queue_setpoint('0, Q_MIN, Q_MAX);                 // and low
    queue_setpoint(Q_MAX, Q_MAX, Q_MAX);
    queue_setpoint(Q_MIN, Q_MIN, Q_MIN);
    queue_setpoint(-32'sd1, -32'sd1, -32'sd1);
    queue_setpoint(32'sd1, 32'sd1, 32'sd1);
    queue_setpoint('0, 32'sh0001_0000, '0);
    queue_setpoint('0, '0, 32'sh0001_0000);
    queue_setpoint(32'sh0001_8000, 32'sh0004_0000, 32'shffff_0000);
    wait_drained();
    settings_used++;

    // mass word with only the dropped top bit set reads as zero mass;
    // step word with only upper bits set reads as zero step
    write_register(REG_MASS, 32'h8000_0000);
    write_register(REG_STEP_TIME, 32'hffff_0000);
    write_register(REG_DAMPING, Q_MIN);
    write_register(REG_STIFFNESS, Q_MAX);
    write_register(8'hff, 32'h1234_5678);            // unknown index
    @(negedge clk);
    queue_setpoint('0, Q_MAX, '0);
    queue_setpoint(Q_MIN, '0, Q_MAX);
    queue_setpoint(Q_MAX, -32'sd1, 32'sd1);
    queue_setpoint('0, '0, '0);
    queue_setpoint($urandom, $urandom, $urandom);
    queue_setpoint(32'sh0001_0000, '0, '0);
    wait_drained();
    settings_used++;

    // heaviest mass, longest step, opposite rails on the gains
    write_register(REG_MASS, 32'h7fff_ffff);
    write_register(REG_STEP_TIME, 32'h0000_ffff);
    write_register(REG_DAMPING, Q_MAX);
    write_register(REG_STIFFNESS, Q_MIN);
    @(negedge clk);
    queue_setpoint(Q_MAX, Q_MIN, Q_MAX);
    queue_setpoint(Q_MIN, Q_MAX, Q_MIN);
    queue_setpoint('0, '0, '0);
    queue_setpoint(-32'sd1, 32'sd1, '0);
    queue_setpoint(32'sh0010_0000, 32'sh0100_0000, 32'shff00_0000);
    queue_setpoint('0, '0, '0);
    wait_drained();
    settings_used++;

    // random part: each phase new gains, then a run of setpoints
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_gains(phase % 5);
      @(negedge clk);
      repeat (ITEMS_PER_PHASE) pending_setpoints.push_back(random_setpoint());
      wait_drained();
      settings_used++;
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d setpoints, checked %0d position commands under %0d gain settings",
             setpoints_sent, commands_checked, settings_used);
    $display("mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, several times the slowest expected run
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
